### src/spi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment pair intersection package
// Widths, queue word layout and small arithmetic helpers shared by the
// front end, the queue and the back end.
// ----------------------------------------------------------------------------
package spi_pkg;

	localparam int COORD_BITS   = 16;
	localparam int FRAC_BITS    = 16;
	localparam int OUT_W        = 32;
	localparam int DIF_W        = COORD_BITS + 1;
	localparam int PRD_W        = 2 * DIF_W;
	localparam int CRD_W        = 2 * COORD_BITS;
	localparam int LIN_W        = CRD_W + 1;
	localparam int DEN_W        = PRD_W + 1;
	localparam int MUL_W        = DIF_W + LIN_W;
	localparam int NUM_W        = MUL_W + 1;
	localparam int MAG_W        = NUM_W + FRAC_BITS;
	localparam int REM_W        = DEN_W + 1;
	localparam int FIFO_DEPTH   = 8;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int FRONT_STAGES = 4;
	localparam int LATENCY      = OUT_W + 8;
	localparam int NCHK         = 8;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic                    contained;
		logic                    crosses;
		logic                    divide;
		logic [OUT_W-1:0]        fx;
		logic [OUT_W-1:0]        fy;
		logic signed [NUM_W-1:0] nx;
		logic signed [NUM_W-1:0] ny;
		logic signed [DEN_W-1:0] den;
	} entry_t;

	typedef struct packed {
		logic             contained;
		logic             crosses;
		logic             divide;
		logic             neg_x;
		logic             neg_y;
		logic [OUT_W-1:0] fx;
		logic [OUT_W-1:0] fy;
	} side_t;

	function automatic logic signed [DIF_W-1:0] dif(input coord_t a, input coord_t b);
		return DIF_W'(a) - DIF_W'(b);
	endfunction

	function automatic logic signed [PRD_W-1:0] mul_d(input logic signed [DIF_W-1:0] a,
			input logic signed [DIF_W-1:0] b);
		return PRD_W'(a) * PRD_W'(b);
	endfunction

	function automatic logic signed [CRD_W-1:0] mul_c(input coord_t a, input coord_t b);
		return CRD_W'(a) * CRD_W'(b);
	endfunction

	function automatic logic signed [MUL_W-1:0] mul_l(input logic signed [DIF_W-1:0] a,
			input logic signed [LIN_W-1:0] b);
		return MUL_W'(a) * MUL_W'(b);
	endfunction

	function automatic logic in_box(input coord_t ax, input coord_t ay, input coord_t bx,
			input coord_t by, input coord_t px, input coord_t py);
		logic ok_x;
		logic ok_y;
		ok_x = (ax < bx) ? (px >= ax && px <= bx) : (px >= bx && px <= ax);
		ok_y = (ay < by) ? (py >= ay && py <= by) : (py >= by && py <= ay);
		return ok_x && ok_y;
	endfunction

	function automatic logic [OUT_W-1:0] fix(input coord_t v);
		logic signed [COORD_BITS+FRAC_BITS+OUT_W-1:0] t;
		t = (COORD_BITS + FRAC_BITS + OUT_W)'(v) <<< FRAC_BITS;
		return t[OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

### src/spi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment pair intersection front end
// Four stage pipeline that runs the on-segment and orientation tests, forms
// the line coefficients and classifies each pair into a queue word.
// ----------------------------------------------------------------------------
module spi_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire spi_pkg::coord_t first_start_x,
	input  wire spi_pkg::coord_t first_start_y,
	input  wire spi_pkg::coord_t first_end_x,
	input  wire spi_pkg::coord_t first_end_y,
	input  wire spi_pkg::coord_t second_start_x,
	input  wire spi_pkg::coord_t second_start_y,
	input  wire spi_pkg::coord_t second_end_x,
	input  wire spi_pkg::coord_t second_end_y,
	output logic                 wr_en,
	output spi_pkg::entry_t      wr_data
);

	typedef logic signed [spi_pkg::DIF_W-1:0] dif_t;
	typedef logic signed [spi_pkg::PRD_W-1:0] prd_t;
	typedef logic signed [spi_pkg::LIN_W-1:0] lin_t;

	logic v_s1, v_s2, v_s3, v_s4;

	dif_t da [spi_pkg::NCHK];
	dif_t db [spi_pkg::NCHK];
	dif_t dc [spi_pkg::NCHK];
	dif_t dd [spi_pkg::NCHK];
	logic [3:0] box;

	dif_t da_s1 [spi_pkg::NCHK];
	dif_t db_s1 [spi_pkg::NCHK];
	dif_t dc_s1 [spi_pkg::NCHK];
	dif_t dd_s1 [spi_pkg::NCHK];
	logic [3:0] box_s1, box_s2;
	spi_pkg::coord_t p1x_s1, p1y_s1, q1x_s1, q1y_s1, p2x_s1, p2y_s1, q2x_s1, q2y_s1;
	spi_pkg::coord_t p1x_s2, p1y_s2, q1x_s2, q1y_s2, p2x_s2, p2y_s2, q2x_s2, q2y_s2;
	spi_pkg::coord_t p1x_s3, p1y_s3, q1x_s3, q1y_s3, p2x_s3, p2y_s3, q2x_s3, q2y_s3;
	spi_pkg::coord_t hx_s4, hy_s4;
	dif_t la_s1, lb_s1, wa_s1, wb_s1;
	dif_t la_s2, lb_s2, wa_s2, wb_s2;
	dif_t la_s3, lb_s3, wa_s3, wb_s3;

	prd_t pa_s2 [spi_pkg::NCHK];
	prd_t pb_s2 [spi_pkg::NCHK];
	logic signed [spi_pkg::CRD_W-1:0] lca_s2, lcb_s2, wca_s2, wcb_s2;
	prd_t dna_s2, dnb_s2;

	logic [3:0] on_s3;
	logic [1:0] oc_s3 [4];
	lin_t lc_s3, wc_s3;
	logic signed [spi_pkg::DEN_W-1:0] den_s3, den_s4;

	logic signed [spi_pkg::MUL_W-1:0] m0_s4, m1_s4, m2_s4, m3_s4;
	logic cont_s4, touch_s4, strad_s4;

	always_comb begin
		da[0] = spi_pkg::dif(second_start_x, first_start_x);
		db[0] = spi_pkg::dif(second_end_y, second_start_y);
		dc[0] = spi_pkg::dif(second_start_y, first_start_y);
		dd[0] = spi_pkg::dif(second_end_x, second_start_x);
		da[1] = spi_pkg::dif(second_start_x, first_end_x);
		db[1] = spi_pkg::dif(second_end_y, second_start_y);
		dc[1] = spi_pkg::dif(second_start_y, first_end_y);
		dd[1] = spi_pkg::dif(second_end_x, second_start_x);
		da[2] = spi_pkg::dif(first_start_x, second_start_x);
		db[2] = spi_pkg::dif(first_end_y, first_start_y);
		dc[2] = spi_pkg::dif(first_start_y, second_start_y);
		dd[2] = spi_pkg::dif(first_end_x, first_start_x);
		da[3] = spi_pkg::dif(first_start_x, second_end_x);
		db[3] = spi_pkg::dif(first_end_y, first_start_y);
		dc[3] = spi_pkg::dif(first_start_y, second_end_y);
		dd[3] = spi_pkg::dif(first_end_x, first_start_x);
		da[4] = spi_pkg::dif(first_end_x, first_start_x);
		db[4] = spi_pkg::dif(second_start_y, first_end_y);
		dc[4] = spi_pkg::dif(first_end_y, first_start_y);
		dd[4] = spi_pkg::dif(second_start_x, first_end_x);
		da[5] = spi_pkg::dif(first_end_x, first_start_x);
		db[5] = spi_pkg::dif(second_end_y, first_end_y);
		dc[5] = spi_pkg::dif(first_end_y, first_start_y);
		dd[5] = spi_pkg::dif(second_end_x, first_end_x);
		da[6] = spi_pkg::dif(second_end_x, second_start_x);
		db[6] = spi_pkg::dif(first_start_y, second_end_y);
		dc[6] = spi_pkg::dif(second_end_y, second_start_y);
		dd[6] = spi_pkg::dif(first_start_x, second_end_x);
		da[7] = spi_pkg::dif(second_end_x, second_start_x);
		db[7] = spi_pkg::dif(first_end_y, second_end_y);
		dc[7] = spi_pkg::dif(second_end_y, second_start_y);
		dd[7] = spi_pkg::dif(first_end_x, second_end_x);
		box[0] = spi_pkg::in_box(second_start_x, second_start_y, second_end_x, second_end_y,
			first_start_x, first_start_y);
		box[1] = spi_pkg::in_box(second_start_x, second_start_y, second_end_x, second_end_y,
			first_end_x, first_end_y);
		box[2] = spi_pkg::in_box(first_start_x, first_start_y, first_end_x, first_end_y,
			second_start_x, second_start_y);
		box[3] = spi_pkg::in_box(first_start_x, first_start_y, first_end_x, first_end_y,
			second_end_x, second_end_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		da_s1 <= da;
		db_s1 <= db;
		dc_s1 <= dc;
		dd_s1 <= dd;
		box_s1 <= box;
		p1x_s1 <= first_start_x;
		p1y_s1 <= first_start_y;
		q1x_s1 <= first_end_x;
		q1y_s1 <= first_end_y;
		p2x_s1 <= second_start_x;
		p2y_s1 <= second_start_y;
		q2x_s1 <= second_end_x;
		q2y_s1 <= second_end_y;
		la_s1 <= spi_pkg::dif(first_start_y, first_end_y);
		lb_s1 <= spi_pkg::dif(first_end_x, first_start_x);
		wa_s1 <= spi_pkg::dif(second_start_y, second_end_y);
		wb_s1 <= spi_pkg::dif(second_end_x, second_start_x);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < spi_pkg::NCHK; i++) begin
			pa_s2[i] <= spi_pkg::mul_d(da_s1[i], db_s1[i]);
			pb_s2[i] <= spi_pkg::mul_d(dc_s1[i], dd_s1[i]);
		end
		lca_s2 <= spi_pkg::mul_c(p1x_s1, q1y_s1);
		lcb_s2 <= spi_pkg::mul_c(q1x_s1, p1y_s1);
		wca_s2 <= spi_pkg::mul_c(p2x_s1, q2y_s1);
		wcb_s2 <= spi_pkg::mul_c(q2x_s1, p2y_s1);
		dna_s2 <= spi_pkg::mul_d(la_s1, wb_s1);
		dnb_s2 <= spi_pkg::mul_d(wa_s1, lb_s1);
		box_s2 <= box_s1;
		la_s2 <= la_s1;
		lb_s2 <= lb_s1;
		wa_s2 <= wa_s1;
		wb_s2 <= wb_s1;
		p1x_s2 <= p1x_s1;
		p1y_s2 <= p1y_s1;
		q1x_s2 <= q1x_s1;
		q1y_s2 <= q1y_s1;
		p2x_s2 <= p2x_s1;
		p2y_s2 <= p2y_s1;
		q2x_s2 <= q2x_s1;
		q2y_s2 <= q2y_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			on_s3[i] <= box_s2[i] && (pa_s2[i] == pb_s2[i]);
			oc_s3[i] <= (pa_s2[i+4] == pb_s2[i+4]) ? 2'd0 :
				((pa_s2[i+4] > pb_s2[i+4]) ? 2'd1 : 2'd2);
		end
		lc_s3 <= spi_pkg::LIN_W'(lca_s2) - spi_pkg::LIN_W'(lcb_s2);
		wc_s3 <= spi_pkg::LIN_W'(wca_s2) - spi_pkg::LIN_W'(wcb_s2);
		den_s3 <= spi_pkg::DEN_W'(dna_s2) - spi_pkg::DEN_W'(dnb_s2);
		la_s3 <= la_s2;
		lb_s3 <= lb_s2;
		wa_s3 <= wa_s2;
		wb_s3 <= wb_s2;
		p1x_s3 <= p1x_s2;
		p1y_s3 <= p1y_s2;
		q1x_s3 <= q1x_s2;
		q1y_s3 <= q1y_s2;
		p2x_s3 <= p2x_s2;
		p2y_s3 <= p2y_s2;
		q2x_s3 <= q2x_s2;
		q2y_s3 <= q2y_s2;
	end

	always_ff @(posedge clk) begin
		m0_s4 <= spi_pkg::mul_l(lb_s3, wc_s3);
		m1_s4 <= spi_pkg::mul_l(wb_s3, lc_s3);
		m2_s4 <= spi_pkg::mul_l(wa_s3, lc_s3);
		m3_s4 <= spi_pkg::mul_l(la_s3, wc_s3);
		den_s4 <= den_s3;
		cont_s4 <= (on_s3[0] && on_s3[1]) || (on_s3[2] && on_s3[3]);
		touch_s4 <= |on_s3;
		strad_s4 <= (oc_s3[0] != oc_s3[1]) && (oc_s3[2] != oc_s3[3]);
		hx_s4 <= on_s3[0] ? p1x_s3 : (on_s3[1] ? q1x_s3 : (on_s3[2] ? p2x_s3 : q2x_s3));
		hy_s4 <= on_s3[0] ? p1y_s3 : (on_s3[1] ? q1y_s3 : (on_s3[2] ? p2y_s3 : q2y_s3));
	end

	always_comb begin
		wr_en = v_s4;
		wr_data.contained = cont_s4;
		wr_data.crosses = !cont_s4 && (touch_s4 || strad_s4);
		wr_data.divide = !cont_s4 && !touch_s4 && strad_s4 && (den_s4 != '0);
		wr_data.fx = (!cont_s4 && touch_s4) ? spi_pkg::fix(hx_s4) : '0;
		wr_data.fy = (!cont_s4 && touch_s4) ? spi_pkg::fix(hy_s4) : '0;
		wr_data.nx = spi_pkg::NUM_W'(m0_s4) - spi_pkg::NUM_W'(m1_s4);
		wr_data.ny = spi_pkg::NUM_W'(m2_s4) - spi_pkg::NUM_W'(m3_s4);
		wr_data.den = den_s4;
	end

endmodule
`default_nettype wire

### src/spi_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment pair intersection queue
// Short word queue between the front end and the back end, with a
// registered read port.
// ----------------------------------------------------------------------------
module spi_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire spi_pkg::entry_t wr_data,
	output logic                 full_soon,
	output logic                 rd_valid_q,
	output spi_pkg::entry_t      rd_data_q
);

	spi_pkg::entry_t mem [spi_pkg::FIFO_DEPTH];
	logic [spi_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [spi_pkg::FIFO_AW:0] cnt_q;
	logic pop;

	assign pop = (cnt_q != '0);
	assign full_soon = cnt_q >=
		(spi_pkg::FIFO_AW + 1)'(spi_pkg::FIFO_DEPTH - spi_pkg::FRONT_STAGES);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (pop) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= pop;
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (spi_pkg::FIFO_AW + 1)'(wr_en) - (spi_pkg::FIFO_AW + 1)'(pop);
		end
	end

endmodule
`default_nettype wire

### src/spi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment pair intersection divider
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit the output width, so only its low bits are developed.
// ----------------------------------------------------------------------------
module spi_div (
	input  wire logic                      clk,
	input  wire logic [spi_pkg::MAG_W-1:0] mag,
	input  wire logic [spi_pkg::DEN_W-1:0] dvs,
	output logic [spi_pkg::OUT_W-1:0]      quo
);

	logic [spi_pkg::REM_W-1:0] rem_s [0:spi_pkg::OUT_W-1];
	logic [spi_pkg::DEN_W-1:0] d_s [0:spi_pkg::OUT_W-1];
	logic [spi_pkg::OUT_W-1:0] low_s [0:spi_pkg::OUT_W];
	logic [spi_pkg::MAG_W-1:0] hi;

	assign hi = mag >> spi_pkg::OUT_W;
	assign quo = low_s[spi_pkg::OUT_W];

	always_ff @(posedge clk) begin
		rem_s[0] <= hi[spi_pkg::REM_W-1:0];
		low_s[0] <= mag[spi_pkg::OUT_W-1:0];
		d_s[0] <= dvs;
	end

	for (genvar k = 0; k < spi_pkg::OUT_W; k++) begin : g_stage
		logic [spi_pkg::REM_W-1:0] sh;
		logic ge;
		assign sh = {rem_s[k][spi_pkg::REM_W-2:0], low_s[k][spi_pkg::OUT_W-1]};
		assign ge = sh >= {1'b0, d_s[k]};
		always_ff @(posedge clk) begin
			low_s[k+1] <= {low_s[k][spi_pkg::OUT_W-2:0], ge};
		end
		if (k < spi_pkg::OUT_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? (sh - {1'b0, d_s[k]}) : sh;
				d_s[k+1] <= d_s[k];
			end
		end
	end

endmodule
`default_nettype wire

### src/spi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment pair intersection back end
// Takes queue words, divides the crossing point numerators by the
// determinant and registers the finished result word.
// ----------------------------------------------------------------------------
module spi_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire spi_pkg::entry_t       in_data,
	output logic                       done,
	output logic                       crosses,
	output logic                       contained,
	output logic signed [spi_pkg::OUT_W-1:0] meet_x,
	output logic signed [spi_pkg::OUT_W-1:0] meet_y
);

	logic [spi_pkg::NUM_W-1:0] ax, ay;
	logic [spi_pkg::DEN_W-1:0] ad;
	logic [spi_pkg::MAG_W-1:0] mag_x, mag_y;
	logic [spi_pkg::OUT_W-1:0] qx, qy;
	spi_pkg::side_t side_s [0:spi_pkg::OUT_W];
	logic [spi_pkg::OUT_W:0] vld_s;
	spi_pkg::side_t fin;

	assign ax = in_data.nx[spi_pkg::NUM_W-1] ? (~in_data.nx + 1'b1) : in_data.nx;
	assign ay = in_data.ny[spi_pkg::NUM_W-1] ? (~in_data.ny + 1'b1) : in_data.ny;
	assign ad = in_data.den[spi_pkg::DEN_W-1] ? (~in_data.den + 1'b1) : in_data.den;
	assign mag_x = spi_pkg::MAG_W'(ax) << spi_pkg::FRAC_BITS;
	assign mag_y = spi_pkg::MAG_W'(ay) << spi_pkg::FRAC_BITS;

	spi_div u_div_x (.clk(clk), .mag(mag_x), .dvs(ad), .quo(qx));
	spi_div u_div_y (.clk(clk), .mag(mag_y), .dvs(ad), .quo(qy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done <= 1'b0;
		end else begin
			vld_s <= {vld_s[spi_pkg::OUT_W-1:0], in_valid};
			done <= vld_s[spi_pkg::OUT_W];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0].contained <= in_data.contained;
		side_s[0].crosses <= in_data.crosses;
		side_s[0].divide <= in_data.divide;
		side_s[0].neg_x <= in_data.nx[spi_pkg::NUM_W-1] ^ in_data.den[spi_pkg::DEN_W-1];
		side_s[0].neg_y <= in_data.ny[spi_pkg::NUM_W-1] ^ in_data.den[spi_pkg::DEN_W-1];
		side_s[0].fx <= in_data.fx;
		side_s[0].fy <= in_data.fy;
		for (int k = 0; k < spi_pkg::OUT_W; k++) begin
			side_s[k+1] <= side_s[k];
		end
	end

	assign fin = side_s[spi_pkg::OUT_W];

	always_ff @(posedge clk) begin
		crosses <= fin.crosses;
		contained <= fin.contained;
		if (fin.divide) begin
			meet_x <= fin.neg_x ? (~qx + 1'b1) : qx;
			meet_y <= fin.neg_y ? (~qy + 1'b1) : qy;
		end else begin
			meet_x <= fin.fx;
			meet_y <= fin.fy;
		end
	end

endmodule
`default_nettype wire

### src/segment_pair_intersection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Segment pair intersection
// Exact intersection test and meeting point of two integer line segments.
// ----------------------------------------------------------------------------
// One segment pair is taken in every clock cycle while busy is low, and its
// result word appears on the outputs with done high after the start word is
// taken, in order. The word passes through the four-stage test pipeline, the
// queue with its registered read, and the 32-stage divider that develops one
// quotient bit per stage. The result cannot be held off, so the queue drains
// every cycle and busy stays low in practice.
// ----------------------------------------------------------------------------
module segment_pair_intersection (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire spi_pkg::coord_t               first_start_x,
	input  wire spi_pkg::coord_t               first_start_y,
	input  wire spi_pkg::coord_t               first_end_x,
	input  wire spi_pkg::coord_t               first_end_y,
	input  wire spi_pkg::coord_t               second_start_x,
	input  wire spi_pkg::coord_t               second_start_y,
	input  wire spi_pkg::coord_t               second_end_x,
	input  wire spi_pkg::coord_t               second_end_y,
	output logic                               done,
	output logic                               crosses,
	output logic                               contained,
	output logic signed [spi_pkg::OUT_W-1:0]   meet_x,
	output logic signed [spi_pkg::OUT_W-1:0]   meet_y
);

	logic wr_en, rd_valid;
	spi_pkg::entry_t wr_data, rd_data;

	spi_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.first_start_x(first_start_x), .first_start_y(first_start_y),
		.first_end_x(first_end_x), .first_end_y(first_end_y),
		.second_start_x(second_start_x), .second_start_y(second_start_y),
		.second_end_x(second_end_x), .second_end_y(second_end_y),
		.wr_en(wr_en), .wr_data(wr_data)
	);

	spi_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_data(wr_data),
		.full_soon(busy), .rd_valid_q(rd_valid), .rd_data_q(rd_data)
	);

	spi_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(rd_valid), .in_data(rd_data),
		.done(done), .crosses(crosses), .contained(contained),
		.meet_x(meet_x), .meet_y(meet_y)
	);

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(spi_pkg::LATENCY) done)
		else $error("result word missing at fixed latency");

	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(crosses && contained))
		else $error("contained pair reported as crossing");

	a_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		done && !crosses |-> meet_x == '0 && meet_y == '0)
		else $error("meeting point set without intersection");
`endif

endmodule
`default_nettype wire
